// ===== rtl/sixteen_bit_vm_instruction_execute_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef SIXTEEN_BIT_VM_INSTRUCTION_EXECUTE_MACROS_SVH
`define SIXTEEN_BIT_VM_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock outside reset.
`define SVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never comes true outside reset.
`define SVM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SVM_ASSERT(label, prop, msg)
`define SVM_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/svm_pkg.sv =====
package svm_pkg;

  // Input and result words
  typedef struct packed {
    logic        opcode;
    logic [15:0] data_word;
  } in_t;

  typedef struct packed {
    logic               write_valid;
    logic signed [15:0] write_value;
    logic               halted;
    logic [2:0]         fault;
    logic [31:0]        clock_count;
  } out_t;

  // Item kinds
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_EXEC = 1'b1;

  // Instruction opcodes
  localparam logic [4:0] OP_LOAD    = 5'd0;
  localparam logic [4:0] OP_STORE   = 5'd1;
  localparam logic [4:0] OP_ADD     = 5'd2;
  localparam logic [4:0] OP_ADDC    = 5'd3;
  localparam logic [4:0] OP_SUB     = 5'd4;
  localparam logic [4:0] OP_SUBC    = 5'd5;
  localparam logic [4:0] OP_AND     = 5'd6;
  localparam logic [4:0] OP_XOR     = 5'd7;
  localparam logic [4:0] OP_COMPL   = 5'd8;
  localparam logic [4:0] OP_SHL     = 5'd9;
  localparam logic [4:0] OP_SHLA    = 5'd10;
  localparam logic [4:0] OP_SHR     = 5'd11;
  localparam logic [4:0] OP_SHRA    = 5'd12;
  localparam logic [4:0] OP_COMP    = 5'd13;
  localparam logic [4:0] OP_GETSTAT = 5'd14;
  localparam logic [4:0] OP_PUTSTAT = 5'd15;
  localparam logic [4:0] OP_JUMP    = 5'd16;
  localparam logic [4:0] OP_JUMPL   = 5'd17;
  localparam logic [4:0] OP_JUMPE   = 5'd18;
  localparam logic [4:0] OP_JUMPG   = 5'd19;
  localparam logic [4:0] OP_CALL    = 5'd20;
  localparam logic [4:0] OP_RET     = 5'd21;
  localparam logic [4:0] OP_READ    = 5'd22;
  localparam logic [4:0] OP_WRITE   = 5'd23;
  localparam logic [4:0] OP_HALT    = 5'd24;
  localparam logic [4:0] OP_NOOP    = 5'd25;

  // Fault codes
  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_BAD_ADDR = 3'd1;
  localparam logic [2:0] FAULT_STACK    = 3'd2;
  localparam logic [2:0] FAULT_PC_PAST  = 3'd3;
  localparam logic [2:0] FAULT_TOO_BIG  = 3'd4;

  // Status flag bits
  localparam int FLAG_CARRY = 0;
  localparam int FLAG_GT    = 1;
  localparam int FLAG_EQ    = 2;
  localparam int FLAG_LT    = 3;
  localparam int FLAG_OVF   = 4;

  // Clock weights
  localparam logic [4:0] CYC_BASIC = 5'd1;
  localparam logic [4:0] CYC_MEM   = 5'd4;
  localparam logic [4:0] CYC_IO    = 5'd28;

  // Stack frame
  localparam logic [2:0] FRAME_LAST = 3'd5;
  localparam logic [2:0] POP_LAST   = 3'd6;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       append;
    logic       fetch;
    logic       decode;
    logic       exec;
    logic       mem_wb;
    logic       push;
    logic       pop;
    logic       finish;
    logic [2:0] step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic halted;
    logic load_mem;
    logic call_ok;
    logic ret_ok;
  } sts_t;

endpackage

// ===== rtl/sixteen_bit_vm_instruction_execute.sv =====
// Sixteen-bit four-register interpreter. A load word (opcode 0) appends a
// program word; an execute word (opcode 1) runs one instruction and returns
// one result word with the write output, halt status, fault code and the
// weighted clock count. Items run one at a time through a single-port program
// memory: a load appends one word, a plain instruction is fetched, decoded and
// executed, a memory load adds a write-back, a call writes a six-word stack
// frame and a return reads it back, one memory access a cycle. A halted machine
// skips the fetch and goes straight to its result. The result sits in an output
// register, so a new item is taken as soon as the previous one is handed off there.
module sixteen_bit_vm_instruction_execute #(
  parameter int MEM_WORDS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svm_pkg::out_t out_data
);
  import svm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_data.opcode),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svm_dpath #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

// ===== rtl/svm_ram.sv =====
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write through one port, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/svm_ctrl.sv =====
`include "sixteen_bit_vm_instruction_execute_macros.svh"

module svm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svm_pkg::sts_t sts,
  output svm_pkg::cmd_t cmd
);
  import svm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_APPEND = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_DECODE = 9'b000001000,
    S_EXEC   = 9'b000010000,
    S_MEMWB  = 9'b000100000,
    S_PUSH   = 9'b001000000,
    S_POP    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Sequence one item through append or fetch, decode, execute, write-back and the stack sweeps
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.halted) begin
            state_nxt = S_DONE;
          end else if (in_opcode == ITEM_LOAD) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        step_nxt = '0;
        if (sts.load_mem) begin
          state_nxt = S_MEMWB;
        end else if (sts.call_ok) begin
          state_nxt = S_PUSH;
        end else if (sts.ret_ok) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MEMWB: begin
        cmd.mem_wb = 1'b1;
        state_nxt  = S_DONE;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == FRAME_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop  = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == POP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SVM_ASSERT(a_halted_skips, (state_r == S_IDLE && in_valid && sts.halted) |=> (state_r == S_DONE), "halted item not sent straight to done")
  `SVM_NEVER(a_push_step, (state_r == S_PUSH && step_r > FRAME_LAST), "push sweep overran frame")
  `SVM_NEVER(a_pop_step, (state_r == S_POP && step_r > POP_LAST), "pop sweep overran frame")

endmodule

// ===== rtl/svm_dpath.sv =====
`include "sixteen_bit_vm_instruction_execute_macros.svh"

module svm_dpath #(
  parameter int MEM_WORDS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  svm_pkg::in_t  in_data,
  input  svm_pkg::cmd_t cmd,
  output svm_pkg::sts_t sts,
  output svm_pkg::out_t out_data
);
  import svm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int LW = $clog2(MEM_WORDS + 1);
  localparam logic [16:0] MEM_W = 17'(MEM_WORDS);

  // Architectural state
  logic [15:0]   gpr_r [4];
  logic [15:0]   gpr_nxt [4];
  logic [4:0]    flags_r, flags_nxt;
  logic [7:0]    pc_r, pc_nxt;
  logic [LW-1:0] sp_r, sp_nxt;
  logic [LW-1:0] lim_r, lim_nxt;
  logic [31:0]   cyc_r, cyc_nxt;
  logic          halted_r, halted_nxt;
  logic [2:0]    fault_r, fault_nxt;

  // Per-item registers
  logic [15:0] ir_r, ir_nxt;
  logic [15:0] data_r, data_nxt;
  logic [15:0] wv_r, wv_nxt;
  logic        wvalid_r, wvalid_nxt;
  out_t        out_r, out_nxt;

  // Memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  // Decoded fields
  logic [4:0]  op;
  logic [1:0]  rd, rs;
  logic        imm;
  logic [7:0]  addr;
  logic [15:0] con, a, b;
  logic [16:0] bc, sum, diff;
  logic [16:0] addr17, lim17, sp17;
  logic [8:0]  pc_inc;
  logic        addr_ok, chk_addr, bad, stack_ok, ret_ok;
  logic [LW-1:0] push_ptr, pop_ptr;
  logic [2:0]  pop_j;
  logic [15:0] push_word;

  assign op     = ir_r[15:11];
  assign rd     = ir_r[10:9];
  assign imm    = ir_r[8];
  assign rs     = ir_r[7:6];
  assign addr   = ir_r[7:0];
  assign con    = {{8{addr[7]}}, addr};
  assign a      = gpr_r[rd];
  assign b      = imm ? con : gpr_r[rs];
  assign bc     = (op == OP_ADDC || op == OP_SUBC) ? (17'(b) + 17'(flags_r[FLAG_CARRY]))
                                                   : 17'(b);
  assign sum    = {1'b0, a} + bc;
  assign diff   = {1'b0, a} - bc;
  assign addr17 = 17'(addr);
  assign lim17  = 17'(lim_r);
  assign sp17   = 17'(sp_r);
  assign pc_inc = 9'(pc_r) + 9'd1;

  // Address and stack checks
  assign addr_ok  = addr17 < lim17;
  assign chk_addr = (op == OP_LOAD && !imm) || (op == OP_STORE) ||
                    (op >= OP_JUMP && op <= OP_CALL && imm);
  assign bad      = chk_addr && !addr_ok;
  assign stack_ok = sp17 > (lim17 + 17'd6);
  assign ret_ok   = sp17 <= (MEM_W - 17'd6);

  assign sts.halted   = halted_r;
  assign sts.load_mem = (op == OP_LOAD) && !imm && addr_ok;
  assign sts.call_ok  = (op == OP_CALL) && imm && addr_ok && stack_ok;
  assign sts.ret_ok   = (op == OP_RET) && imm && ret_ok;

  // Stack frame pointers and push word
  assign push_ptr = sp_r - LW'(1) - LW'(cmd.step);
  assign pop_ptr  = sp_r + LW'(cmd.step);
  assign pop_j    = cmd.step - 3'd1;

  always_comb begin
    case (cmd.step)
      3'd0:    push_word = 16'(pc_inc);
      3'd5:    push_word = 16'(flags_r);
      default: push_word = gpr_r[2'(cmd.step - 3'd1)];
    endcase
  end

  // Drive the memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc_r[AW-1:0];
    ram_wdata = a;
    if (cmd.append) begin
      ram_we   = (lim17 != MEM_W);
      ram_addr = lim_r[AW-1:0];
      ram_wdata = data_r;
    end else if (cmd.exec) begin
      ram_we   = (op == OP_STORE) && addr_ok;
      ram_addr = addr[AW-1:0];
    end else if (cmd.push) begin
      ram_we    = 1'b1;
      ram_addr  = push_ptr[AW-1:0];
      ram_wdata = push_word;
    end else if (cmd.pop) begin
      ram_addr = pop_ptr[AW-1:0];
    end
  end

  svm_ram #(
    .WIDTH(16),
    .DEPTH(MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Next-state logic for the machine
  always_comb begin
    logic [8:0] nx;
    logic [4:0] cyc_add;
    logic       taken, halt_now, hold_pc;
    nx         = pc_inc;
    cyc_add    = '0;
    taken      = 1'b0;
    halt_now   = 1'b0;
    hold_pc    = 1'b0;
    gpr_nxt    = gpr_r;
    flags_nxt  = flags_r;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    lim_nxt    = lim_r;
    cyc_nxt    = cyc_r;
    halted_nxt = halted_r;
    fault_nxt  = fault_r;
    ir_nxt     = ir_r;
    data_nxt   = data_r;
    wv_nxt     = wv_r;
    wvalid_nxt = wvalid_r;
    out_nxt    = out_r;

    if (cmd.capture) begin
      data_nxt   = in_data.data_word;
      wv_nxt     = '0;
      wvalid_nxt = 1'b0;
    end

    // Append a program word
    if (cmd.append) begin
      if (lim17 == MEM_W) begin
        halted_nxt = 1'b1;
        fault_nxt  = FAULT_TOO_BIG;
      end else begin
        lim_nxt = lim_r + LW'(1);
      end
    end

    if (cmd.decode) begin
      ir_nxt = ram_rdata;
    end

    // Execute one instruction
    if (cmd.exec) begin
      if (bad) begin
        halted_nxt = 1'b1;
        fault_nxt  = FAULT_BAD_ADDR;
      end else begin
        case (op)
          OP_LOAD: begin
            if (imm) begin
              gpr_nxt[rd] = con;
              cyc_add     = CYC_BASIC;
            end else begin
              cyc_add = CYC_MEM;
            end
          end
          OP_STORE: cyc_add = CYC_MEM;
          OP_ADD, OP_ADDC: begin
            if (a[15] == bc[15] && sum[15] != a[15]) begin
              flags_nxt[FLAG_OVF] = 1'b1;
            end
            flags_nxt[FLAG_CARRY] = sum[16];
            gpr_nxt[rd]           = sum[15:0];
            cyc_add               = CYC_BASIC;
          end
          OP_SUB, OP_SUBC: begin
            flags_nxt[FLAG_CARRY] = diff[16];
            gpr_nxt[rd]           = diff[15:0];
            cyc_add               = CYC_BASIC;
          end
          OP_AND: begin
            gpr_nxt[rd] = a & b;
            cyc_add     = CYC_BASIC;
          end
          OP_XOR: begin
            gpr_nxt[rd] = a ^ b;
            cyc_add     = CYC_BASIC;
          end
          OP_COMPL: begin
            gpr_nxt[rd] = ~a;
            cyc_add     = CYC_BASIC;
          end
          OP_SHL, OP_SHLA: begin
            // Arithmetic form ORs the old sign bit into the shifted bit 15
            flags_nxt[FLAG_CARRY] = a[15];
            gpr_nxt[rd] = {a[14] | ((op == OP_SHLA) && a[15]), a[13:0], 1'b0};
            cyc_add     = CYC_BASIC;
          end
          OP_SHR, OP_SHRA: begin
            flags_nxt[FLAG_CARRY] = a[0];
            gpr_nxt[rd] = {(op == OP_SHRA) ? a[15] : 1'b0, a[15:1]};
            cyc_add     = CYC_BASIC;
          end
          OP_COMP: begin
            flags_nxt[FLAG_LT] = $signed(a) < $signed(b);
            flags_nxt[FLAG_EQ] = a == b;
            flags_nxt[FLAG_GT] = $signed(a) > $signed(b);
            cyc_add            = CYC_BASIC;
          end
          OP_GETSTAT: begin
            gpr_nxt[rd] = 16'(flags_r);
            cyc_add     = CYC_BASIC;
          end
          OP_PUTSTAT: begin
            flags_nxt = a[4:0];
            cyc_add   = CYC_BASIC;
          end
          OP_JUMP, OP_JUMPL, OP_JUMPE, OP_JUMPG: begin
            if (imm) begin
              taken = (op == OP_JUMP) ||
                      (op == OP_JUMPL && flags_r[FLAG_LT]) ||
                      (op == OP_JUMPE && flags_r[FLAG_EQ]) ||
                      (op == OP_JUMPG && flags_r[FLAG_GT]);
              cyc_add = CYC_BASIC;
            end
          end
          OP_CALL: begin
            if (imm) begin
              cyc_add = CYC_MEM;
              hold_pc = 1'b1;
              if (!stack_ok) begin
                halted_nxt = 1'b1;
                fault_nxt  = FAULT_STACK;
              end
            end
          end
          OP_RET: begin
            if (imm) begin
              cyc_add = CYC_MEM;
              hold_pc = ret_ok;
            end
          end
          OP_READ: begin
            gpr_nxt[rd] = data_r;
            cyc_add     = CYC_IO;
          end
          OP_WRITE: begin
            wv_nxt     = a;
            wvalid_nxt = 1'b1;
            cyc_add    = CYC_IO;
          end
          OP_HALT: begin
            halt_now   = 1'b1;
            halted_nxt = 1'b1;
            fault_nxt  = FAULT_NONE;
            cyc_add    = CYC_BASIC;
          end
          OP_NOOP: cyc_add = CYC_BASIC;
          default: cyc_add = '0;
        endcase
        cyc_nxt = cyc_r + 32'(cyc_add);
        // Advance the program counter, stop past the end of memory
        if (!hold_pc) begin
          if (taken) begin
            nx = 9'(addr);
          end
          if (!halt_now && 17'(nx) >= MEM_W) begin
            halted_nxt = 1'b1;
            fault_nxt  = FAULT_PC_PAST;
          end
          pc_nxt = nx[7:0];
        end
      end
    end

    if (cmd.mem_wb) begin
      gpr_nxt[rd] = ram_rdata;
    end

    // Finish the call frame
    if (cmd.push && cmd.step == FRAME_LAST) begin
      sp_nxt = sp_r - LW'(6);
      pc_nxt = addr;
    end

    // Restore the frame one word a cycle
    if (cmd.pop && cmd.step != 3'd0) begin
      case (pop_j)
        3'd0: flags_nxt = ram_rdata[4:0];
        3'd5: begin
          if (17'(ram_rdata) >= MEM_W) begin
            halted_nxt = 1'b1;
            fault_nxt  = FAULT_PC_PAST;
          end
          pc_nxt = ram_rdata[7:0];
          sp_nxt = sp_r + LW'(6);
        end
        default: gpr_nxt[2'(3'd4 - pop_j)] = ram_rdata;
      endcase
    end

    // Load the result word
    if (cmd.finish) begin
      out_nxt.write_valid = wvalid_r;
      out_nxt.write_value = wvalid_r ? wv_r : '0;
      out_nxt.halted      = halted_r;
      out_nxt.fault       = fault_r;
      out_nxt.clock_count = cyc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        gpr_r[i] <= '0;
      end
      flags_r  <= '0;
      pc_r     <= '0;
      sp_r     <= LW'(MEM_WORDS);
      lim_r    <= '0;
      cyc_r    <= '0;
      halted_r <= 1'b0;
      fault_r  <= FAULT_NONE;
    end else begin
      gpr_r    <= gpr_nxt;
      flags_r  <= flags_nxt;
      pc_r     <= pc_nxt;
      sp_r     <= sp_nxt;
      lim_r    <= lim_nxt;
      cyc_r    <= cyc_nxt;
      halted_r <= halted_nxt;
      fault_r  <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r     <= ir_nxt;
    data_r   <= data_nxt;
    wv_r     <= wv_nxt;
    wvalid_r <= wvalid_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

  `SVM_ASSERT(a_fault_halts, (fault_r != FAULT_NONE) |-> halted_r, "fault set without halt")
  `SVM_NEVER(a_limit_range, (lim17 > MEM_W), "program limit past memory")
  `SVM_NEVER(a_sp_range, (sp17 > MEM_W), "stack pointer past memory")

endmodule
